// ----- design/i2c_rtm_pkg.sv -----
// Shared types and constants of the I2C register-transaction master.
package i2c_rtm_pkg;

    localparam int MAX_BURST = 8;
    localparam int BUF_AW    = $clog2(MAX_BURST);
    localparam int CNT_W     = $clog2(MAX_BURST + 1);

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_BEGW  = 2'd2;
    localparam logic [1:0] OP_BEGR  = 2'd3;

    localparam logic CFG_DEV_ADDR  = 1'b0;
    localparam logic CFG_ACK_POLLS = 1'b1;

    localparam logic [6:0] DEV_ADDR_RST  = 7'd50;
    localparam logic [3:0] ACK_POLLS_RST = 4'd3;

    // Input beat: op, register_address, byte_count, write_data, sda_in
    localparam int IN_W  = 23;
    localparam int IN_TW = 24;
    // Output beat tdata: scl, sda_out, busy_res, read_data, read_valid,
    // done_res, nack_error
    localparam int OUT_TW = 16;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] reg_addr;
        logic [3:0] byte_count;
        logic [7:0] write_data;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       busy;
        logic [7:0] read_data;
        logic       read_valid;
        logic       last;
        logic       done;
        logic       nack_error;
    } result_t;

    typedef enum logic [9:0] {
        ST_IDLE       = 10'b00_0000_0001,
        ST_START      = 10'b00_0000_0010,
        ST_ADDR_W     = 10'b00_0000_0100,
        ST_REG        = 10'b00_0000_1000,
        ST_WDATA      = 10'b00_0001_0000,
        ST_RESTART    = 10'b00_0010_0000,
        ST_ADDR_R     = 10'b00_0100_0000,
        ST_RDATA      = 10'b00_1000_0000,
        ST_STOP       = 10'b01_0000_0000,
        ST_STOP_ABORT = 10'b10_0000_0000
    } stage_t;

endpackage

// ----- design/i2c_rtm_fifo.sv -----
// Two-entry queue between the front and the back of the master.
module i2c_rtm_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_valid,
    output logic                  wr_ready,
    input  i2c_rtm_pkg::item_t    wr_item,
    output logic                  rd_valid,
    input  logic                  rd_ready,
    output i2c_rtm_pkg::item_t    rd_item
);
    i2c_rtm_pkg::item_t mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_item  = mem_reg[rp_reg];
    assign push = wr_valid && wr_ready;
    assign pop  = rd_valid && rd_ready;

    always_comb begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            mem_reg[wp_reg] <= wr_item;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !push) else $error("queue overflow");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("bad queue count");
    a_empty_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd0 |-> wp_reg == rp_reg) else $error("pointer mismatch");
`endif
endmodule

// ----- design/i2c_rtm_seq.sv -----
// Bus sequencer: runs one queued item per cycle while out_ready does not stall it; registers each result.
module i2c_rtm_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [6:0]            dev_addr,
    input  logic [3:0]            ack_polls,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  i2c_rtm_pkg::item_t    in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output i2c_rtm_pkg::result_t  out_res
);
    localparam int AW = i2c_rtm_pkg::BUF_AW;
    localparam int CW = i2c_rtm_pkg::CNT_W;

    i2c_rtm_pkg::stage_t stage_reg, stage_next;
    logic [1:0]  q_reg, q_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  sh_reg, sh_next;
    logic [CW-1:0] bidx_reg, bidx_next, blen_reg, blen_next, lcnt_reg, lcnt_next;
    logic [7:0]  hreg_reg, hreg_next;
    logic        rd_reg, rd_next;
    logic [3:0]  poll_reg, poll_next;
    logic        scl_reg, scl_next, sda_reg, sda_next;
    logic [7:0]  wbuf [i2c_rtm_pkg::MAX_BURST];
    logic        ovalid_reg;
    i2c_rtm_pkg::result_t ores_reg, res;
    logic        take, wr_en, adv;
    logic [AW-1:0] wr_idx;
    logic [3:0]  lim, cnt_c;
    logic [CW-1:0] bidx_inc;

    assign in_ready  = !ovalid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = ovalid_reg;
    assign out_res   = ores_reg;
    assign wr_idx    = lcnt_reg[AW-1:0];
    assign bidx_inc  = bidx_reg + CW'(1);

    always_comb begin
        stage_next = stage_reg; q_next = q_reg; bit_next = bit_reg;
        sh_next = sh_reg; bidx_next = bidx_reg; blen_next = blen_reg;
        lcnt_next = lcnt_reg; hreg_next = hreg_reg; rd_next = rd_reg;
        poll_next = poll_reg; scl_next = scl_reg; sda_next = sda_reg;
        wr_en = 1'b0; adv = 1'b1;
        res = '0;
        lim = (ack_polls == 4'd0) ? 4'd1 : ack_polls;
        cnt_c = in_item.byte_count;
        if (cnt_c == 4'd0) cnt_c = 4'd1;
        if (cnt_c > 4'(i2c_rtm_pkg::MAX_BURST)) cnt_c = 4'(i2c_rtm_pkg::MAX_BURST);
        case (in_item.op)
            i2c_rtm_pkg::OP_TICK: begin
                if (stage_reg == i2c_rtm_pkg::ST_IDLE) begin
                    scl_next = 1'b1; sda_next = 1'b1;
                end else begin
                    scl_next = q_reg[1];
                    sda_next = 1'b1;
                    case (stage_reg)
                        i2c_rtm_pkg::ST_START, i2c_rtm_pkg::ST_RESTART: begin
                            scl_next = (q_reg == 2'd1) || (q_reg == 2'd2);
                            sda_next = !q_reg[1];
                            if (q_reg == 2'd3) begin
                                adv = 1'b0; q_next = 2'd0; bit_next = 4'd0;
                                if (stage_reg == i2c_rtm_pkg::ST_START) begin
                                    stage_next = i2c_rtm_pkg::ST_ADDR_W;
                                    sh_next = {dev_addr, 1'b0};
                                end else begin
                                    stage_next = i2c_rtm_pkg::ST_ADDR_R;
                                    sh_next = {dev_addr, 1'b1};
                                end
                            end
                        end
                        i2c_rtm_pkg::ST_ADDR_W, i2c_rtm_pkg::ST_REG,
                        i2c_rtm_pkg::ST_WDATA, i2c_rtm_pkg::ST_ADDR_R: begin
                            if (!bit_reg[3]) begin
                                sda_next = sh_reg[7];
                                if (q_reg == 2'd3) begin
                                    sh_next = {sh_reg[6:0], 1'b0};
                                    bit_next = bit_reg + 4'd1;
                                end
                            end else if (q_reg == 2'd0) begin
                                poll_next = 4'd0;
                            end else if (q_reg == 2'd2) begin
                                if (in_item.sda_in) begin
                                    poll_next = poll_reg + 4'd1;
                                    adv = 1'b0;
                                    if (poll_next >= lim) begin
                                        stage_next = i2c_rtm_pkg::ST_STOP_ABORT;
                                        q_next = 2'd0;
                                    end
                                end
                            end else if (q_reg == 2'd3) begin
                                adv = 1'b0; q_next = 2'd0; bit_next = 4'd0;
                                case (stage_reg)
                                    i2c_rtm_pkg::ST_ADDR_W: begin
                                        stage_next = i2c_rtm_pkg::ST_REG;
                                        sh_next = hreg_reg;
                                    end
                                    i2c_rtm_pkg::ST_REG: begin
                                        if (rd_reg) begin
                                            stage_next = i2c_rtm_pkg::ST_RESTART;
                                            bit_next = bit_reg;
                                        end else begin
                                            bidx_next = '0;
                                            stage_next = i2c_rtm_pkg::ST_WDATA;
                                            sh_next = wbuf[0];
                                        end
                                    end
                                    i2c_rtm_pkg::ST_WDATA: begin
                                        bidx_next = bidx_inc;
                                        if (bidx_inc >= blen_reg) begin
                                            stage_next = i2c_rtm_pkg::ST_STOP;
                                            bit_next = bit_reg;
                                        end else begin
                                            sh_next = wbuf[bidx_inc[AW-1:0]];
                                        end
                                    end
                                    default: begin
                                        bidx_next = '0;
                                        stage_next = i2c_rtm_pkg::ST_RDATA;
                                        sh_next = 8'd0;
                                    end
                                endcase
                            end
                        end
                        i2c_rtm_pkg::ST_RDATA: begin
                            if (!bit_reg[3]) begin
                                if (q_reg == 2'd2)
                                    sh_next = {sh_reg[6:0], in_item.sda_in};
                                else if (q_reg == 2'd3)
                                    bit_next = bit_reg + 4'd1;
                            end else begin
                                sda_next = (bidx_inc >= blen_reg);
                                if (q_reg == 2'd0) begin
                                    res.read_valid = 1'b1;
                                    res.read_data = sh_reg;
                                    res.last = (bidx_inc >= blen_reg);
                                end else if (q_reg == 2'd3) begin
                                    adv = 1'b0; q_next = 2'd0;
                                    bidx_next = bidx_inc;
                                    if (bidx_inc >= blen_reg) begin
                                        stage_next = i2c_rtm_pkg::ST_STOP;
                                    end else begin
                                        bit_next = 4'd0; sh_next = 8'd0;
                                    end
                                end
                            end
                        end
                        i2c_rtm_pkg::ST_STOP, i2c_rtm_pkg::ST_STOP_ABORT: begin
                            scl_next = (q_reg != 2'd0);
                            sda_next = q_reg[1];
                            if (q_reg[1]) begin
                                res.done = 1'b1;
                                res.nack_error = (stage_reg == i2c_rtm_pkg::ST_STOP_ABORT);
                                stage_next = i2c_rtm_pkg::ST_IDLE;
                                q_next = 2'd0; bit_next = 4'd0; lcnt_next = '0;
                                adv = 1'b0;
                            end
                        end
                        default: begin
                            stage_next = i2c_rtm_pkg::ST_IDLE; q_next = 2'd0;
                            scl_next = 1'b1; sda_next = 1'b1; adv = 1'b0;
                        end
                    endcase
                    if (adv) q_next = q_reg + 2'd1;
                end
            end
            i2c_rtm_pkg::OP_LOAD: begin
                if (stage_reg == i2c_rtm_pkg::ST_IDLE &&
                    lcnt_reg < CW'(i2c_rtm_pkg::MAX_BURST)) begin
                    wr_en = 1'b1;
                    lcnt_next = lcnt_reg + CW'(1);
                end
            end
            default: begin
                if (stage_reg == i2c_rtm_pkg::ST_IDLE) begin
                    blen_next = CW'(cnt_c);
                    hreg_next = in_item.reg_addr;
                    rd_next = (in_item.op == i2c_rtm_pkg::OP_BEGR);
                    bidx_next = '0; bit_next = 4'd0; poll_next = 4'd0; q_next = 2'd0;
                    stage_next = i2c_rtm_pkg::ST_START;
                end
            end
        endcase
        res.scl = scl_next;
        res.sda_out = sda_next;
        res.busy = (stage_next != i2c_rtm_pkg::ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= i2c_rtm_pkg::ST_IDLE;
            q_reg <= '0; bit_reg <= '0; sh_reg <= '0; bidx_reg <= '0;
            blen_reg <= '0; lcnt_reg <= '0; hreg_reg <= '0; rd_reg <= 1'b0;
            poll_reg <= '0; scl_reg <= 1'b1; sda_reg <= 1'b1;
            ovalid_reg <= 1'b0;
        end else begin
            if (take) begin
                stage_reg <= stage_next; q_reg <= q_next; bit_reg <= bit_next;
                sh_reg <= sh_next; bidx_reg <= bidx_next; blen_reg <= blen_next;
                lcnt_reg <= lcnt_next; hreg_reg <= hreg_next; rd_reg <= rd_next;
                poll_reg <= poll_next; scl_reg <= scl_next; sda_reg <= sda_next;
            end
            if (take) ovalid_reg <= 1'b1;
            else if (out_ready) ovalid_reg <= 1'b0;
        end
        if (take) ores_reg <= res;
        if (take && wr_en) wbuf[wr_idx] <= in_item.write_data;
    end

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        take && res.done |=> stage_reg == i2c_rtm_pkg::ST_IDLE)
        else $error("done without idle");
    a_err_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ovalid_reg && ores_reg.nack_error |-> ores_reg.done)
        else $error("error without done");
    a_lcnt: assert property (@(posedge aclk) disable iff (!aresetn)
        lcnt_reg <= CW'(i2c_rtm_pkg::MAX_BURST)) else $error("load count overrun");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ovalid_reg && !out_ready |=> $stable(ores_reg)) else $error("result lost");
`endif
endmodule

// ----- design/i2c_register_transaction_master_core.sv -----
// Top level of the I2C register-transaction master.
//
//  channel | ports                          | beat
//  --------+--------------------------------+----------------------------------
//  s_      | s_tvalid s_tready s_tdata      | one op (tick, load, begin)
//  m_      | m_tvalid m_tready m_tdata m_tlast | one result per input beat
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data | register write
//
// One input beat per cycle sustained while m_ is not stalled; every beat
// yields exactly one result. The beat enters a two-entry queue, then the
// sequencer runs it and holds its result in an output register until taken.
// Stalls on m_ back up through the queue to s_tready.
// aresetn (synchronous, active low) idles the bus with both lines released.
module i2c_register_transaction_master_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] op, [9:2] register_address, [13:10] byte_count,
    // [21:14] write_data, [22] sda_in, [23] zero
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] scl, [1] sda_out, [2] busy_res, [10:3] read_data, [11] read_valid,
    // [12] done_res, [13] nack_error, [15:14] zero
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);
    i2c_rtm_pkg::item_t   s_item, q_item;
    i2c_rtm_pkg::result_t res;
    logic       q_valid, q_ready;
    logic [6:0] dev_addr_reg;
    logic [3:0] polls_reg;

    assign s_item.op         = s_tdata[1:0];
    assign s_item.reg_addr   = s_tdata[9:2];
    assign s_item.byte_count = s_tdata[13:10];
    assign s_item.write_data = s_tdata[21:14];
    assign s_item.sda_in     = s_tdata[22];

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= i2c_rtm_pkg::DEV_ADDR_RST;
            polls_reg    <= i2c_rtm_pkg::ACK_POLLS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                i2c_rtm_pkg::CFG_DEV_ADDR:  dev_addr_reg <= cfg_data;
                i2c_rtm_pkg::CFG_ACK_POLLS: polls_reg    <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    i2c_rtm_fifo u_fifo (
        .aclk, .aresetn,
        .wr_valid(s_tvalid), .wr_ready(s_tready), .wr_item(s_item),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
    );

    i2c_rtm_seq u_seq (
        .aclk, .aresetn,
        .dev_addr(dev_addr_reg), .ack_polls(polls_reg),
        .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tdata = {2'b00, res.nack_error, res.done, res.read_valid,
                      res.read_data, res.busy, res.sda_out, res.scl};
    assign m_tlast = res.last;
endmodule
